// ===== rtl/pca_pkg.sv =====
// Package for the pixel color adjust block: widths, types, coefficients,
// register indexes and small arithmetic helpers. No dependencies.
package pca_pkg;

  localparam int PIX_W      = 8;
  localparam int IDX_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int VAL_W      = 36;
  localparam int PROD_W     = 56;
  localparam int PIPE_DEPTH = 14;
  localparam int NZ_DEPTH   = 9;
  localparam int NZ_DELAY   = PIPE_DEPTH - NZ_DEPTH;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [16:0]       coef_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } pix_t;

  typedef struct packed {
    logic [15:0] sat;
    logic        hue_en;
    logic [15:0] hue_cos;
    logic [15:0] hue_sin;
    logic [14:0] gray;
    logic [15:0] contrast;
    logic [15:0] bright;
    logic [14:0] nz;
    logic        bypass;
  } cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAT      = 4'd0,
    REG_HUE_EN   = 4'd1,
    REG_HUE_COS  = 4'd2,
    REG_HUE_SIN  = 4'd3,
    REG_GRAY     = 4'd4,
    REG_CONTRAST = 4'd5,
    REG_BRIGHT   = 4'd6,
    REG_NOISE    = 4'd7
  } reg_idx_t;

  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam val_t        MID_Q14 = val_t'(2088960);

  localparam coef_t LUMA_R = 17'sd3483;
  localparam coef_t LUMA_G = 17'sd11718;
  localparam coef_t LUMA_B = 17'sd1183;
  localparam coef_t YQ_R   = 17'sd4899;
  localparam coef_t YQ_G   = 17'sd9617;
  localparam coef_t YQ_B   = 17'sd1868;
  localparam coef_t IQ_R   = 17'sd9765;
  localparam coef_t IQ_G   = -17'sd4489;
  localparam coef_t IQ_B   = -17'sd5276;
  localparam coef_t QQ_R   = 17'sd3457;
  localparam coef_t QQ_G   = -17'sd8569;
  localparam coef_t QQ_B   = 17'sd5112;
  localparam coef_t BK_RI  = 17'sd15663;
  localparam coef_t BK_RQ  = 17'sd10174;
  localparam coef_t BK_GI  = -17'sd4456;
  localparam coef_t BK_GQ  = -17'sd10600;
  localparam coef_t BK_BI  = -17'sd18121;
  localparam coef_t BK_BQ  = 17'sd27902;

  localparam logic [63:0] HASH_GOLD = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_C1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_C2   = 64'hc4ceb9fe1a85ec53;

  function automatic prod_t mulk(val_t a, coef_t k);
    return prod_t'(a) * prod_t'(k);
  endfunction

  // Q28 to Q14, round half up (floor of the shifted sum).
  function automatic val_t q14(prod_t v);
    prod_t t;
    t = v + prod_t'(8192);
    return t[VAL_W+13:14];
  endfunction

  function automatic logic [PIX_W-1:0] to_byte(val_t v);
    logic [PIX_W-1:0] b;
    if (v[VAL_W-1]) begin
      b = '0;
    end else if (v[VAL_W-2:22] != '0) begin
      b = '1;
    end else begin
      b = v[21:14];
    end
    return b;
  endfunction

endpackage

// ===== rtl/pca_in_if.sv =====
// Input pixel channel: valid/ready with the pixel, its index and frame number.
// Depends on pca_pkg for widths.
interface pca_in_if;
  logic                       valid;
  logic                       ready;
  logic [pca_pkg::PIX_W-1:0]  red_in;
  logic [pca_pkg::PIX_W-1:0]  green_in;
  logic [pca_pkg::PIX_W-1:0]  blue_in;
  logic [pca_pkg::IDX_W-1:0]  pixel_index;
  logic [pca_pkg::IDX_W-1:0]  frame_number;

  modport source (output valid, red_in, green_in, blue_in, pixel_index, frame_number,
                  input ready);
  modport sink (input valid, red_in, green_in, blue_in, pixel_index, frame_number,
                output ready);
endinterface

// ===== rtl/pca_out_if.sv =====
// Result pixel channel: valid/ready with the adjusted color.
// Depends on pca_pkg for widths.
interface pca_out_if;
  logic                      valid;
  logic                      ready;
  logic [pca_pkg::PIX_W-1:0] red_out;
  logic [pca_pkg::PIX_W-1:0] green_out;
  logic [pca_pkg::PIX_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== rtl/pca_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on pca_pkg for widths.
interface pca_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pca_pkg::CFG_IDX_W-1:0]  index;
  logic [pca_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pixel_color_adjust.sv =====
// Top level of the pixel color adjust block: config registers, noise and
// color pipelines, output register with skid. Depends on pca_pkg, the
// pca_*_if interfaces, pca_cfg, pca_noise and pca_color.
//
// Usage:
//  - in_ch carries one pixel per request: red/green/blue, its linear index
//    and the frame number (noise seed). A request is taken when valid and
//    ready are both high at a rising edge.
//  - out_ch returns one adjusted pixel per input pixel, in order.
//  - cfg_ch writes one register per request (index 0..7, others dropped);
//    it is always ready. Write only while no pixel is in flight.
//  - Path: 14 pipeline stages, then the output register, to out_ch.valid.
//  - Throughput: one pixel per clock while the skid slot is free. The deepest
//    path per stage is one multiply of at most 36x17 or 32x32 bits with its
//    adder, or one 64-bit add of the hash.
//  - Stall: when out_ch.ready drops, the output register holds its pixel
//    and one more pixel lands in the skid register; then in_ch.ready drops
//    and every stage holds until the skid drains.
//  - Reset (rst_n low, synchronous) clears all valid bits and loads neutral
//    settings, so the block passes pixels through unchanged.
module pixel_color_adjust (
  input  logic      clk,
  input  logic      rst_n,
  pca_in_if.sink    in_ch,
  pca_out_if.source out_ch,
  pca_cfg_if.sink   cfg_ch
);
  import pca_pkg::*;

  cfg_t cfg;
  val_t noise;
  pix_t in_pix, up_pix, out_pix_r, skid_pix_r;
  logic up_vld, en, out_vld_r, skid_vld_r;

  // advance the whole pipeline while the skid slot is free
  assign en          = !skid_vld_r;
  assign in_ch.ready = en;

  assign in_pix.r = in_ch.red_in;
  assign in_pix.g = in_ch.green_in;
  assign in_pix.b = in_ch.blue_in;

  pca_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pca_noise u_noise (
    .clk     (clk),
    .en      (en),
    .frame   (in_ch.frame_number),
    .pix_idx (in_ch.pixel_index),
    .nz      (cfg.nz),
    .noise   (noise)
  );

  pca_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_pix    (in_pix),
    .cfg       (cfg),
    .noise     (noise),
    .out_valid (up_vld),
    .out_pix   (up_pix)
  );

  // output register plus one skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ch.ready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= up_vld;
      end
    end else if (up_vld && en) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ch.ready) begin
      out_pix_r <= skid_vld_r ? skid_pix_r : up_pix;
    end else if (en) begin
      skid_pix_r <= up_pix;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.red_out   = out_pix_r.r;
  assign out_ch.green_out = out_pix_r.g;
  assign out_ch.blue_out  = out_pix_r.b;
endmodule

// ===== rtl/pca_cfg.sv =====
// Configuration registers with derived clamps and the neutral-bypass flag.
// Depends on pca_pkg and pca_cfg_if.
module pca_cfg (
  input  logic          clk,
  input  logic          rst_n,
  pca_cfg_if.sink       cfg_ch,
  output pca_pkg::cfg_t cfg
);
  import pca_pkg::*;

  logic [15:0] sat_r, cos_r, sin_r, contrast_r, bright_r;
  logic        hue_en_r;
  logic [14:0] gray_r, nz_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r      <= ONE_Q14;
      hue_en_r   <= 1'b0;
      cos_r      <= ONE_Q14;
      sin_r      <= '0;
      gray_r     <= '0;
      contrast_r <= ONE_Q14;
      bright_r   <= ONE_Q14;
      nz_r       <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SAT:      sat_r      <= cfg_ch.data;
        REG_HUE_EN:   hue_en_r   <= cfg_ch.data[0];
        REG_HUE_COS:  cos_r      <= cfg_ch.data;
        REG_HUE_SIN:  sin_r      <= cfg_ch.data;
        REG_GRAY:     gray_r     <= cfg_ch.data[14:0];
        REG_CONTRAST: contrast_r <= cfg_ch.data;
        REG_BRIGHT:   bright_r   <= cfg_ch.data;
        REG_NOISE:    nz_r       <= cfg_ch.data[14:0];
        default: ;
      endcase
    end
  end

  function automatic logic near_one(logic [15:0] g);
    return (g >= ONE_Q14 - 16'd1) && (g <= ONE_Q14 + 16'd1);
  endfunction

  always_comb begin
    cfg.sat      = sat_r;
    cfg.hue_en   = hue_en_r;
    cfg.hue_cos  = cos_r;
    cfg.hue_sin  = sin_r;
    cfg.gray     = (gray_r > ONE_Q14[14:0]) ? ONE_Q14[14:0] : gray_r;
    cfg.contrast = contrast_r;
    cfg.bright   = bright_r;
    cfg.nz       = (nz_r > ONE_Q14[14:0]) ? ONE_Q14[14:0] : nz_r;
    cfg.bypass   = near_one(sat_r) && near_one(contrast_r) && near_one(bright_r) &&
                   !hue_en_r && (gray_r < 15'd2) && (nz_r == '0);
  end
endmodule

// ===== rtl/pca_noise.sv =====
// Hashed noise pipeline: golden-ratio key, 64-bit fmix in 32-bit partial
// products, scaling to Q14. Depends on pca_pkg.
module pca_noise (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pca_pkg::IDX_W-1:0] frame,
  input  logic [pca_pkg::IDX_W-1:0] pix_idx,
  input  logic [14:0]               nz,
  output pca_pkg::val_t             noise
);
  import pca_pkg::*;

  logic [63:0] k0_r, m0a_r, m0b_r, x2_r, x4_r, w_r;
  logic [31:0] k1_r, pix1_r, m1a_r, m2a_r, m1b_r, m2b_r;
  logic [15:0] m6_r;
  logic signed [31:0] pr7_r;
  val_t n9_r;
  val_t dly_r [NZ_DELAY];

  logic [63:0] key2, s4, s6;
  logic [35:0] u8;
  logic [19:0] a8;
  logic [20:0] s8;
  logic [16:0] e8;
  logic [20:0] q8;

  always_comb begin
    key2 = k0_r + {k1_r, 32'd0} + {32'd0, pix1_r};
    s4   = m0a_r + {m1a_r + m2a_r, 32'd0};
    s6   = m0b_r + {m1b_r + m2b_r, 32'd0};
    u8   = w_r[36:1];
    a8   = u8[35:16];
    s8   = {1'b0, a8} + {5'd0, u8[15:0]};
    e8   = {12'd0, s8[20:16]} + {1'b0, s8[15:0]};
    q8   = {1'b0, a8} + {16'd0, s8[20:16]} + {20'd0, (e8 >= 17'd65535)};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // key = frame * golden + index
      k0_r   <= {32'd0, frame} * {32'd0, HASH_GOLD[31:0]};
      k1_r   <= 32'(frame * HASH_GOLD[63:32]);
      pix1_r <= pix_idx;
      x2_r   <= key2 ^ (key2 >> 33);
      // first fmix multiply
      m0a_r  <= {32'd0, x2_r[31:0]} * {32'd0, HASH_C1[31:0]};
      m1a_r  <= 32'(x2_r[31:0] * HASH_C1[63:32]);
      m2a_r  <= 32'(x2_r[63:32] * HASH_C1[31:0]);
      x4_r   <= s4 ^ (s4 >> 33);
      // second fmix multiply
      m0b_r  <= {32'd0, x4_r[31:0]} * {32'd0, HASH_C2[31:0]};
      m1b_r  <= 32'(x4_r[31:0] * HASH_C2[63:32]);
      m2b_r  <= 32'(x4_r[63:32] * HASH_C2[31:0]);
      m6_r   <= s6[15:0] ^ s6[48:33];
      // (2m - 65535) * nz
      pr7_r  <= 32'($signed({1'b0, m6_r, 1'b0}) - 18'sd65535) * $signed({17'd0, nz});
      // offset so the divide by 131070 sees a non-negative value
      w_r    <= 64'(64'(signed'(pr7_r)) * 64'sd56) + 64'd60128690175;
      n9_r   <= val_t'(q8) - val_t'(458752);
      dly_r[0] <= n9_r;
      for (int i = 1; i < NZ_DELAY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign noise = dly_r[NZ_DELAY-1];
endmodule

// ===== rtl/pca_color.sv =====
// Color datapath: luma, saturation, YIQ hue rotation, gray blend, contrast,
// brightness, noise add, clamp and neutral bypass. Carries the valid bits. Depends on pca_pkg.
module pca_color (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  pca_pkg::pix_t in_pix,
  input  pca_pkg::cfg_t cfg,
  input  pca_pkg::val_t noise,
  output logic          out_valid,
  output pca_pkg::pix_t out_pix
);
  import pca_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  pix_t  pix_r [PIPE_DEPTH];
  val_t  luma_r [9];
  val_t  diff1_r [3], c3_r [3], c4_r [3], c5_r [3], c6_r [3], c7_r [3], c8_r [3];
  val_t  h9_r [3], d11_r [3], c13_r [3];
  prod_t p2_r [3], s8_r [3], p10_r [3], p12_r [3], p14_r [3];
  prod_t y4_r, i4_r, q4_r, pa_r, pb_r, pc_r, pd_r;
  val_t  yy5_r, ii5_r, qq5_r, yy6_r, yy7_r, yy8_r, ir7_r, qr7_r;
  val_t  luma0, rgb0 [3], fin [3];
  coef_t sat_k, cos_k, sin_k, gray_k, ungray_k, con_k, bri_k;

  always_comb begin
    rgb0[0]  = val_t'(in_pix.r);
    rgb0[1]  = val_t'(in_pix.g);
    rgb0[2]  = val_t'(in_pix.b);
    luma0    = val_t'(mulk(rgb0[0], LUMA_R) + mulk(rgb0[1], LUMA_G) + mulk(rgb0[2], LUMA_B));
    sat_k    = coef_t'({1'b0, cfg.sat});
    cos_k    = coef_t'($signed(cfg.hue_cos));
    sin_k    = coef_t'($signed(cfg.hue_sin));
    gray_k   = coef_t'({2'b0, cfg.gray});
    ungray_k = coef_t'({1'b0, ONE_Q14}) - gray_k;
    con_k    = coef_t'({1'b0, cfg.contrast});
    bri_k    = coef_t'({1'b0, cfg.bright});
    for (int k = 0; k < 3; k++) begin
      fin[k] = q14(p14_r[k]) + noise;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r[0]  <= in_pix;
      luma_r[0] <= luma0;
      for (int i = 1; i < PIPE_DEPTH; i++) pix_r[i] <= pix_r[i-1];
      for (int i = 1; i < 9; i++) luma_r[i] <= luma_r[i-1];
      // saturation around luma
      for (int k = 0; k < 3; k++) begin
        diff1_r[k] <= (rgb0[k] <<< 14) - luma0;
        p2_r[k]    <= mulk(diff1_r[k], sat_k);
        c3_r[k]    <= luma_r[1] + q14(p2_r[k]);
        c4_r[k]    <= c3_r[k];
        c5_r[k]    <= c4_r[k];
        c6_r[k]    <= c5_r[k];
        c7_r[k]    <= c6_r[k];
        c8_r[k]    <= c7_r[k];
      end
      // YIQ forward
      y4_r  <= mulk(c3_r[0], YQ_R) + mulk(c3_r[1], YQ_G) + mulk(c3_r[2], YQ_B);
      i4_r  <= mulk(c3_r[0], IQ_R) + mulk(c3_r[1], IQ_G) + mulk(c3_r[2], IQ_B);
      q4_r  <= mulk(c3_r[0], QQ_R) + mulk(c3_r[1], QQ_G) + mulk(c3_r[2], QQ_B);
      yy5_r <= q14(y4_r);
      ii5_r <= q14(i4_r);
      qq5_r <= q14(q4_r);
      // rotation
      pa_r  <= mulk(ii5_r, cos_k);
      pb_r  <= mulk(qq5_r, sin_k);
      pc_r  <= mulk(ii5_r, sin_k);
      pd_r  <= mulk(qq5_r, cos_k);
      yy6_r <= yy5_r;
      ir7_r <= q14(pa_r - pb_r);
      qr7_r <= q14(pc_r + pd_r);
      yy7_r <= yy6_r;
      // back to RGB
      s8_r[0] <= mulk(ir7_r, BK_RI) + mulk(qr7_r, BK_RQ);
      s8_r[1] <= mulk(ir7_r, BK_GI) + mulk(qr7_r, BK_GQ);
      s8_r[2] <= mulk(ir7_r, BK_BI) + mulk(qr7_r, BK_BQ);
      yy8_r   <= yy7_r;
      for (int k = 0; k < 3; k++) begin
        h9_r[k]  <= cfg.hue_en ? (yy8_r + q14(s8_r[k])) : c8_r[k];
        p10_r[k] <= mulk(h9_r[k], ungray_k) + mulk(luma_r[8], gray_k);
        d11_r[k] <= q14(p10_r[k]) - MID_Q14;
        p12_r[k] <= mulk(d11_r[k], con_k);
        c13_r[k] <= q14(p12_r[k]) + MID_Q14;
        p14_r[k] <= mulk(c13_r[k], bri_k);
      end
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];

  always_comb begin
    if (cfg.bypass) begin
      out_pix = pix_r[PIPE_DEPTH-1];
    end else begin
      out_pix.r = to_byte(fin[0]);
      out_pix.g = to_byte(fin[1]);
      out_pix.b = to_byte(fin[2]);
    end
  end
endmodule

// ===== verif/tb_pca_if.sv =====
`timescale 1ns / 100ps
// Testbench side of the pixel color adjust channels: no new interfaces are
// needed, the RTL interfaces pca_in_if, pca_out_if and pca_cfg_if are reused.
// This file holds the shared pixel request type. Depends on pca_pkg.
package tb_pca_types;
  import pca_pkg::*;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [31:0] index;
    logic [31:0] frame;
  } pix_req_t;
endpackage

// ===== verif/tb_pixel_color_adjust.sv =====
`timescale 1ns / 100ps
// Testbench for pixel_color_adjust: drives pixel requests and register writes,
// predicts each adjusted pixel in fixed point and checks results in order.
// Depends on pca_pkg, tb_pca_types and the pca_*_if interfaces.
module tb_pixel_color_adjust;
  import pca_pkg::*;
  import tb_pca_types::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pca_in_if  in_ch ();
  pca_out_if out_ch ();
  pca_cfg_if cfg_ch ();

  pixel_color_adjust i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the register file, updated at each accepted write.
  logic [15:0] sh_sat, sh_cos, sh_sin, sh_con, sh_bri;
  logic        sh_hue;
  logic [14:0] sh_gray, sh_noise;

  pix_req_t    pix_pending[$];
  logic [23:0] rgb_expected[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          pixels_sent = 0;
  int          pixels_queued = 0;
  bit          in_idle_ok = 1'b1;
  bit          out_idle_ok = 1'b1;
  int          hold_cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;

  function automatic longint fdiv(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint rnd14(longint v);
    return fdiv(v + 8192, 16384);
  endfunction

  function automatic logic [7:0] clamp_byte(longint v);
    if (v < 0) return 8'd0;
    if (v / 16384 > 255) return 8'd255;
    return 8'(v / 16384);
  endfunction

  function automatic bit close_to_one(logic [15:0] g);
    return g >= 16383 && g <= 16385;
  endfunction

  function automatic logic [63:0] hash_mix(logic [63:0] x);
    x = x ^ (x >> 33);
    x = x * HASH_C1;
    x = x ^ (x >> 33);
    x = x * HASH_C2;
    x = x ^ (x >> 33);
    return x;
  endfunction

  // Work out the adjusted pixel for the current register settings.
  function automatic logic [23:0] adjust_pixel(pix_req_t p);
    longint c[3], luma, gr, nz, sat, yy, ii, qq, ir, qr, m, num, n, hc, hs;
    logic [63:0] key;
    if (close_to_one(sh_sat) && close_to_one(sh_con) && close_to_one(sh_bri) &&
        !sh_hue && sh_gray < 2 && sh_noise == 0)
      return {p.r, p.g, p.b};
    gr  = (sh_gray > 16384) ? 16384 : longint'(sh_gray);
    nz  = (sh_noise > 16384) ? 16384 : longint'(sh_noise);
    sat = longint'(sh_sat);
    hc  = longint'($signed(sh_cos));
    hs  = longint'($signed(sh_sin));
    luma = 3483 * longint'(p.r) + 11718 * longint'(p.g) + 1183 * longint'(p.b);
    c[0] = longint'(p.r) * 16384;
    c[1] = longint'(p.g) * 16384;
    c[2] = longint'(p.b) * 16384;
    for (int k = 0; k < 3; k++) c[k] = luma + rnd14((c[k] - luma) * sat);
    if (sh_hue) begin
      yy = rnd14(4899 * c[0] + 9617 * c[1] + 1868 * c[2]);
      ii = rnd14(9765 * c[0] - 4489 * c[1] - 5276 * c[2]);
      qq = rnd14(3457 * c[0] - 8569 * c[1] + 5112 * c[2]);
      ir = rnd14(ii * hc - qq * hs);
      qr = rnd14(ii * hs + qq * hc);
      c[0] = yy + rnd14(15663 * ir + 10174 * qr);
      c[1] = yy + rnd14(-4456 * ir - 10600 * qr);
      c[2] = yy + rnd14(-18121 * ir + 27902 * qr);
    end
    for (int k = 0; k < 3; k++) begin
      c[k] = rnd14(c[k] * (16384 - gr) + luma * gr);
      c[k] = rnd14((c[k] - 2088960) * longint'(sh_con)) + 2088960;
      c[k] = rnd14(c[k] * longint'(sh_bri));
    end
    if (nz != 0) begin
      key = {32'd0, p.frame} * HASH_GOLD + {32'd0, p.index};
      m = longint'(hash_mix(key) & 64'hffff);
      num = (2 * m - 65535) * 28 * nz;
      n = fdiv(2 * num + 65535, 2 * 65535);
      for (int k = 0; k < 3; k++) c[k] = c[k] + n;
    end
    return {clamp_byte(c[0]), clamp_byte(c[1]), clamp_byte(c[2])};
  endfunction

  // Driver: advance to the next pending pixel once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rgb_expected.insert(rgb_expected.size(),
                            adjust_pixel({in_ch.red_in, in_ch.green_in, in_ch.blue_in,
                                          in_ch.pixel_index, in_ch.frame_number}));
        pixels_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (in_idle_ok && $urandom_range(0, 9) == 0) begin
          // start an idle burst on the sender side
          in_gap = $urandom_range(0, 4);
          in_ch.valid <= 1'b0;
        end else if (pix_pending.size() > 0) begin
          pix_req_t p;
          p = pix_pending.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.red_in       <= p.r;
          in_ch.green_in     <= p.g;
          in_ch.blue_in      <= p.b;
          in_ch.pixel_index  <= p.index;
          in_ch.frame_number <= p.frame;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each returned pixel with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (rgb_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result pixel %h %h %h",
                     out_ch.red_out, out_ch.green_out, out_ch.blue_out);
        end else begin
          logic [23:0] want;
          want = rgb_expected.pop_front();
          if ({out_ch.red_out, out_ch.green_out, out_ch.blue_out} !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       results_seen, want[23:16], want[15:8], want[7:0],
                       out_ch.red_out, out_ch.green_out, out_ch.blue_out);
          end
        end
      end
      if (hold_cycles > 0) begin
        // long receiver stall, counted down here
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (out_idle_ok && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_SAT:      sh_sat   = value;
      REG_HUE_EN:   sh_hue   = value[0];
      REG_HUE_COS:  sh_cos   = value;
      REG_HUE_SIN:  sh_sin   = value;
      REG_GRAY:     sh_gray  = value[14:0];
      REG_CONTRAST: sh_con   = value;
      REG_BRIGHT:   sh_bri   = value;
      REG_NOISE:    sh_noise = value[14:0];
      default: ;
    endcase
  endtask

  // Wait for every queued pixel to come back before touching the registers.
  task automatic drain;
    while (results_seen < pixels_queued)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void add_pixel(pix_req_t p);
    pix_pending.insert(pix_pending.size(), p);
    pixels_queued++;
  endfunction

  function automatic pix_req_t rand_pixel();
    pix_req_t p;
    p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom);
    if ($urandom_range(0, 7) == 0) p.r = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 7) == 0) p.g = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 7) == 0) p.b = $urandom_range(0, 1) ? 8'hff : 8'h00;
    p.index = $urandom;
    p.frame = $urandom;
    return p;
  endfunction

  task automatic random_settings();
    write_reg(REG_SAT, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40000)));
    write_reg(REG_HUE_EN, 16'($urandom_range(0, 1)));
    write_reg(REG_HUE_COS, 16'($urandom_range(0, 32768) - 16384));
    write_reg(REG_HUE_SIN, 16'($urandom_range(0, 7) == 0 ? $urandom
                                                       : $urandom_range(0, 32768) - 16384));
    write_reg(REG_GRAY, 16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32767)));
    write_reg(REG_CONTRAST, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32768)));
    write_reg(REG_BRIGHT, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32768)));
    write_reg(REG_NOISE, 16'($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 32767)));
  endtask

  task automatic queue_pixels(int count);
    for (int k = 0; k < count; k++) add_pixel(rand_pixel());
  endtask

  task automatic directed_pixels();
    pix_req_t p;
    p = '0;                                        add_pixel(p);
    p = {8'hff, 8'hff, 8'hff, 32'hffffffff, 32'hffffffff}; add_pixel(p);
    p = {8'hff, 8'h00, 8'h00, 32'h0, 32'hffffffff}; add_pixel(p);
    p = {8'h00, 8'hff, 8'h00, 32'hffffffff, 32'h0}; add_pixel(p);
    p = {8'h00, 8'h00, 8'hff, 32'h5555aaaa, 32'haaaa5555}; add_pixel(p);
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.red_in = '0; in_ch.green_in = '0; in_ch.blue_in = '0;
    in_ch.pixel_index = '0; in_ch.frame_number = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    sh_sat = ONE_Q14; sh_hue = 1'b0; sh_cos = ONE_Q14; sh_sin = '0;
    sh_gray = '0; sh_con = ONE_Q14; sh_bri = ONE_Q14; sh_noise = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Neutral bypass straight out of reset.
    directed_pixels();
    drain();
    // Neutral within one code, gray_mix 1: still bypassed.
    write_reg(REG_SAT, 16'd16383); write_reg(REG_CONTRAST, 16'd16385);
    write_reg(REG_BRIGHT, 16'd16383); write_reg(REG_GRAY, 16'd1);
    directed_pixels();
    drain();
    // Hue rotation enabled at the neutral angle.
    write_reg(REG_HUE_EN, 16'd1);
    directed_pixels();
    drain();
    // Extremes: full gain, out-of-range hue factors, gray and noise above one.
    write_reg(REG_SAT, 16'hffff); write_reg(REG_HUE_COS, 16'h8000);
    write_reg(REG_HUE_SIN, 16'h7fff); write_reg(REG_GRAY, 16'h7fff);
    write_reg(REG_CONTRAST, 16'hffff); write_reg(REG_BRIGHT, 16'hffff);
    write_reg(REG_NOISE, 16'h7fff);
    directed_pixels();
    drain();
    // Zero gains, noise at exactly one, hue off.
    write_reg(REG_SAT, 16'd0); write_reg(REG_HUE_EN, 16'd0); write_reg(REG_GRAY, 16'd16384);
    write_reg(REG_CONTRAST, 16'd0); write_reg(REG_BRIGHT, 16'd0);
    write_reg(REG_NOISE, 16'd16384);
    directed_pixels();
    drain();
    // Out-of-list register index: must be ignored.
    write_reg(reg_idx_t'(4'd9), 16'hffff);

    // Backpressure: hold the receiver for a long stretch while pixels queue up.
    random_settings();
    queue_pixels(60);
    hold_cycles = 120;
    wait (hold_cycles == 0);
    drain();

    // Random phases, each with fresh settings.
    for (int ph = 0; ph < 12; ph++) begin
      random_settings();
      if (ph == 11) begin
        in_idle_ok = 1'b0;
        out_idle_ok = 1'b0;
      end
      queue_pixels(60);
      drain();
    end
    // Last phase back to neutral, no idling.
    write_reg(REG_SAT, ONE_Q14); write_reg(REG_HUE_EN, 16'd0);
    write_reg(REG_GRAY, 16'd0); write_reg(REG_CONTRAST, ONE_Q14);
    write_reg(REG_BRIGHT, ONE_Q14); write_reg(REG_NOISE, 16'd0);
    queue_pixels(40);
    drain();

    $display("Sent %0d pixels across bypass, hue, gray, contrast, brightness and noise",
             pixels_sent);
    $display("settings; %0d results checked, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
